### rtl/fbep_pkg.sv
package fbep_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_DATA_PER_BLOCK = 4'd0;
  localparam logic [3:0] CFG_FEC_PER_BLOCK  = 4'd1;

  localparam logic [5:0] DATA_PER_BLOCK_RST = 6'd8;
  localparam logic [5:0] FEC_PER_BLOCK_RST  = 6'd4;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_STORE   = 3'd0,
    KIND_IGNORE  = 3'd1,
    KIND_PAIR    = 3'd2,
    KIND_SUMMARY = 3'd3,
    KIND_RESTART = 3'd4
  } kind_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DECIDE,
    ST_RST_OUT,
    ST_FL_RD,
    ST_CNT,
    ST_SUM,
    ST_PRIO,
    ST_FL_CLR,
    ST_ST_RD,
    ST_ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic decide;
    logic emit_restart;
    logic flush_rd;
    logic cnt_step;
    logic emit_summary;
    logic prio_step;
    logic flush_clr;
    logic store_rd;
    logic store_emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic do_restart;
    logic do_flush;
    logic cnt_done;
    logic prio_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/fbep_if.sv
interface fbep_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pkt_seq;
  logic        crc_ok;

  modport source (output valid, output pkt_seq, output crc_ok, input ready);
  modport sink   (input valid, input pkt_seq, input crc_ok, output ready);
endinterface

interface fbep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  buffer_index;
  logic [5:0]  slot_index;
  logic [4:0]  data_index;
  logic [4:0]  fec_index;
  logic [5:0]  data_missing;
  logic [5:0]  data_corrupt;
  logic [5:0]  fec_missing;
  logic [5:0]  fec_corrupt;
  logic        failed;
  logic [31:0] deliver_mask;
  logic        last;

  modport source (output valid, output kind, output buffer_index, output slot_index,
                  output data_index, output fec_index, output data_missing,
                  output data_corrupt, output fec_missing, output fec_corrupt,
                  output failed, output deliver_mask, output last, input ready);
  modport sink   (input valid, input kind, input buffer_index, input slot_index,
                  input data_index, input fec_index, input data_missing,
                  input data_corrupt, input fec_missing, input fec_corrupt,
                  input failed, input deliver_mask, input last, output ready);
endinterface

### rtl/fbep_div.sv
module fbep_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic [31:0] quot_o,
  output logic [5:0]  rem_o,
  output logic        done_o
);

  logic [31:0] quo_q, quo_d;
  logic [5:0]  rem_q, rem_d;
  logic [6:0]  dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [6:0]  trial;
  logic        fit;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[31]};
    fit    = (trial >= dvs_q);
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], fit};
      rem_d = fit ? 6'(trial - dvs_q) : trial[5:0];
      cnt_d = 5'(cnt_q + 5'd1);
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign quot_o = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### rtl/fbep_ctrl.sv
module fbep_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fbep_pkg::sts_t sts_i,
  output fbep_pkg::cmd_t cmd_o
);
  import fbep_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_DIV;
      ST_DIV:     if (sts_i.div_done) state_d = ST_SCAN;
      ST_SCAN:    if (sts_i.scan_last) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (sts_i.do_restart) state_d = ST_RST_OUT;
        else if (sts_i.do_flush) state_d = ST_FL_RD;
        else state_d = ST_ST_RD;
      end
      ST_RST_OUT: if (sts_i.out_free) state_d = ST_ST_RD;
      ST_FL_RD:   state_d = ST_CNT;
      ST_CNT:     if (sts_i.cnt_done) state_d = ST_SUM;
      ST_SUM:     if (sts_i.out_free) state_d = ST_PRIO;
      ST_PRIO:    if (sts_i.prio_done) state_d = ST_FL_CLR;
      ST_FL_CLR:  state_d = ST_ST_RD;
      ST_ST_RD:   state_d = ST_ST_OUT;
      ST_ST_OUT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_SCAN:    cmd_o.scan_step = 1'b1;
      ST_DECIDE:  cmd_o.decide = 1'b1;
      ST_RST_OUT: cmd_o.emit_restart = sts_i.out_free;
      ST_FL_RD:   cmd_o.flush_rd = 1'b1;
      ST_CNT:     cmd_o.cnt_step = !sts_i.cnt_done;
      ST_SUM:     cmd_o.emit_summary = sts_i.out_free;
      ST_PRIO:    cmd_o.prio_step = !sts_i.prio_done && sts_i.out_free;
      ST_FL_CLR:  cmd_o.flush_clr = 1'b1;
      ST_ST_RD:   cmd_o.store_rd = 1'b1;
      ST_ST_OUT:  cmd_o.store_emit = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

### rtl/fbep_dp.sv
module fbep_dp #(
  parameter int BLOCK_BUFFERS  = 1,
  parameter int MAX_PER_KIND   = 32,
  parameter int RESTART_WINDOW = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_idx_i,
  input  logic [5:0]     cfg_data_i,
  input  logic [31:0]    seq_i,
  input  logic           crc_i,
  input  fbep_pkg::cmd_t cmd_i,
  output fbep_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [2:0]     kind_o,
  output logic [3:0]     buffer_index_o,
  output logic [5:0]     slot_index_o,
  output logic [4:0]     data_index_o,
  output logic [4:0]     fec_index_o,
  output logic [5:0]     data_missing_o,
  output logic [5:0]     data_corrupt_o,
  output logic [5:0]     fec_missing_o,
  output logic [5:0]     fec_corrupt_o,
  output logic           failed_o,
  output logic [31:0]    deliver_mask_o,
  output logic           last_o
);
  import fbep_pkg::*;

  localparam int SLOTS = 2 * MAX_PER_KIND;
  localparam int SW    = $clog2(SLOTS);
  localparam int BIW   = (BLOCK_BUFFERS > 1) ? $clog2(BLOCK_BUFFERS) : 1;
  localparam int RW    = 2 * SLOTS;
  localparam logic [33:0] SPAN = 34'(RESTART_WINDOW * BLOCK_BUFFERS);
  localparam logic [BIW-1:0] LAST_BUF = BIW'(BLOCK_BUFFERS - 1);
  localparam logic [5:0] MPK = 6'(MAX_PER_KIND);

  function automatic logic [6:0] data_slot(input logic [5:0] i, input logic [5:0] f);
    data_slot = (i < f) ? {i, 1'b0} : 7'(f + i);
  endfunction

  function automatic logic [6:0] fec_slot(input logic [5:0] i, input logic [5:0] d);
    fec_slot = (i < d) ? {i, 1'b1} : 7'(d + i);
  endfunction

  // Configuration registers
  logic [5:0] cfg_d_q, cfg_f_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_d_q <= DATA_PER_BLOCK_RST;
      cfg_f_q <= FEC_PER_BLOCK_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DATA_PER_BLOCK) cfg_d_q <= cfg_data_i;
      else if (cfg_idx_i == CFG_FEC_PER_BLOCK) cfg_f_q <= cfg_data_i;
    end
  end

  // Saturated counts, latched per transaction
  logic [5:0] d_sat, f_sat, d_q, f_q;
  logic       crc_q;
  assign d_sat = (cfg_d_q == 6'd0) ? 6'd1 : ((cfg_d_q > MPK) ? MPK : cfg_d_q);
  assign f_sat = (cfg_f_q > MPK) ? MPK : cfg_f_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      d_q   <= d_sat;
      f_q   <= f_sat;
      crc_q <= crc_i;
    end
  end

  // Block number and slot
  logic [31:0] blk;
  logic [5:0]  slot;
  logic        div_done;
  fbep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.accept),
    .dividend_i (seq_i),
    .divisor_i  (7'(d_sat) + 7'(f_sat)),
    .quot_o     (blk),
    .rem_o      (slot),
    .done_o     (div_done)
  );

  // Buffer block numbers with occupancy bits
  logic [31:0]              blk_mem [BLOCK_BUFFERS];
  logic [BLOCK_BUFFERS-1:0] blk_live_q;
  logic signed [32:0]       newest_q;

  logic [BIW-1:0]     sidx_q, min_idx_q, found_idx_q;
  logic signed [32:0] minv_q, sval;
  logic               min_live_q, found_ok_q, slive;

  assign slive = blk_live_q[sidx_q];
  assign sval  = slive ? $signed({1'b0, blk_mem[sidx_q]}) : -33'sd1;

  // Sweep of the buffers: lowest block number and a match on this block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q     <= '0;
      found_ok_q <= 1'b0;
    end else if (cmd_i.accept) begin
      sidx_q     <= '0;
      found_ok_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      sidx_q <= BIW'(sidx_q + 1'b1);
      if (!found_ok_q && slive && blk_mem[sidx_q] == blk) begin
        found_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (sidx_q == '0 || sval < minv_q) begin
        minv_q     <= sval;
        min_idx_q  <= sidx_q;
        min_live_q <= slive;
      end
      if (!found_ok_q && slive && blk_mem[sidx_q] == blk) found_idx_q <= sidx_q;
    end
  end

  // Eviction decision
  logic signed [33:0] blk_span;
  logic               newer, restart, evict;
  assign blk_span = $signed({2'b00, blk}) + $signed(SPAN);
  assign newer    = $signed({1'b0, blk}) > newest_q;
  assign restart  = blk_span < $signed({newest_q[32], newest_q});
  assign evict    = (newer || restart) && crc_q;

  logic [BIW-1:0] tgt_q, st_idx_q;
  logic           st_ok_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      tgt_q    <= restart ? '0 : min_idx_q;
      st_ok_q  <= evict || found_ok_q;
      st_idx_q <= evict ? (restart ? '0 : min_idx_q) : found_idx_q;
      if (evict) blk_mem[restart ? '0 : min_idx_q] <= blk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_live_q <= '0;
      newest_q   <= -33'sd1;
    end else if (cmd_i.decide && evict) begin
      newest_q <= $signed({1'b0, blk});
      if (restart) begin
        blk_live_q <= BLOCK_BUFFERS'(1);
      end else begin
        blk_live_q[min_idx_q] <= 1'b1;
      end
    end
  end

  // Slot mark memory: one row per buffer, good marks over valid marks
  logic [RW-1:0]            row_mem [BLOCK_BUFFERS];
  logic [BLOCK_BUFFERS-1:0] row_live_q;
  logic [RW-1:0]            rd_q, row_w, row_new;
  logic                     rd_live_q;
  logic [SLOTS-1:0]         vld, gd;
  logic [BIW-1:0]           rd_addr;
  logic                     rd_en, wr_en;
  logic [SW-1:0]            slot_s;

  assign rd_en   = cmd_i.flush_rd || cmd_i.store_rd;
  assign rd_addr = cmd_i.flush_rd ? tgt_q : st_idx_q;
  assign row_w   = rd_live_q ? rd_q : '0;
  assign vld     = row_w[SLOTS-1:0];
  assign gd      = row_w[RW-1:SLOTS];
  assign slot_s  = slot[SW-1:0];
  assign wr_en   = cmd_i.store_emit && st_ok_q && !gd[slot_s];

  always_comb begin
    row_new = row_w;
    row_new[slot_s] = 1'b1;
    row_new[SLOTS + int'(slot_s)] = crc_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= row_mem[rd_addr];
    if (wr_en) row_mem[st_idx_q] <= row_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_live_q <= '0;
      rd_live_q  <= 1'b0;
    end else begin
      if (rd_en) rd_live_q <= row_live_q[rd_addr];
      if (cmd_i.decide && evict && restart) row_live_q <= '0;
      else if (cmd_i.flush_clr) row_live_q[tgt_q] <= 1'b0;
      else if (wr_en) row_live_q[st_idx_q] <= 1'b1;
    end
  end

  // Counting pass over the flushed row, one packet per cycle
  logic [5:0]  ci_q;
  logic        cph_q;
  logic [5:0]  dm_q, dc_q, fm_q, fc_q;
  logic [31:0] vmask_q;
  logic [6:0]  cs_w;
  logic [SW-1:0] cs;
  logic        cnt_done;

  assign cs_w     = cph_q ? fec_slot(ci_q, d_q) : data_slot(ci_q, f_q);
  assign cs       = cs_w[SW-1:0];
  assign cnt_done = cph_q && (ci_q == f_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush_rd) begin
      ci_q    <= '0;
      cph_q   <= 1'b0;
      dm_q    <= '0;
      dc_q    <= '0;
      fm_q    <= '0;
      fc_q    <= '0;
      vmask_q <= '0;
    end else if (cmd_i.cnt_step) begin
      if (!cph_q) begin
        if (!vld[cs]) dm_q <= 6'(dm_q + 1'b1);
        else begin
          vmask_q[ci_q[4:0]] <= 1'b1;
          if (!gd[cs]) dc_q <= 6'(dc_q + 1'b1);
        end
        if (6'(ci_q + 1'b1) == d_q) begin
          cph_q <= 1'b1;
          ci_q  <= '0;
        end else begin
          ci_q <= 6'(ci_q + 1'b1);
        end
      end else begin
        if (!vld[cs]) fm_q <= 6'(fm_q + 1'b1);
        else if (!gd[cs]) fc_q <= 6'(fc_q + 1'b1);
        ci_q <= 6'(ci_q + 1'b1);
      end
    end
  end

  logic [6:0]  good_c;
  logic        failed;
  logic [31:0] full_mask;
  assign good_c    = 7'(f_q) - 7'(fm_q) - 7'(fc_q);
  assign failed    = (7'(dm_q) + 7'(dc_q)) > good_c;
  assign full_mask = ~(32'hFFFF_FFFF << d_q);

  // Repair pair selection, one decision per cycle while the result register is free
  logic [5:0]    di_q, fi_q;
  logic [6:0]    good_q, miss_q;
  logic [6:0]    ds_w, fs_w;
  logic [SW-1:0] ds, fs;
  logic          dv, dg, fv, fg, pair, prio_done;

  assign ds_w      = data_slot(di_q, f_q);
  assign fs_w      = fec_slot(fi_q, d_q);
  assign ds        = ds_w[SW-1:0];
  assign fs        = fs_w[SW-1:0];
  assign dv        = vld[ds];
  assign dg        = gd[ds];
  assign fv        = vld[fs];
  assign fg        = gd[fs];
  assign prio_done = !((di_q < d_q) && (fi_q < f_q));
  assign pair      = !(dv && dg) && !(dv && !dg && good_q <= miss_q) && fv
                     && !(!fg && miss_q > good_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_summary) begin
      di_q   <= '0;
      fi_q   <= '0;
      good_q <= good_c;
      miss_q <= 7'(dm_q);
    end else if (cmd_i.prio_step) begin
      if (dv && dg) di_q <= 6'(di_q + 1'b1);
      else if (dv && !dg && good_q <= miss_q) di_q <= 6'(di_q + 1'b1);
      else if (!fv) fi_q <= 6'(fi_q + 1'b1);
      else if (!fg && miss_q > good_q) fi_q <= 6'(fi_q + 1'b1);
      else begin
        if (!dv) miss_q <= 7'(miss_q - 1'b1);
        if (fg) good_q <= 7'(good_q - 1'b1);
        di_q <= 6'(di_q + 1'b1);
        fi_q <= 6'(fi_q + 1'b1);
      end
    end
  end

  // Result register
  logic out_valid_q, out_free, load;
  logic [2:0]  kind_q;
  logic [3:0]  bidx_q;
  logic [5:0]  sidx_out_q;
  logic [4:0]  didx_q, fidx_q;
  logic [5:0]  odm_q, odc_q, ofm_q, ofc_q;
  logic        ofail_q, olast_q;
  logic [31:0] omask_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign load     = cmd_i.emit_restart || cmd_i.emit_summary || cmd_i.store_emit
                    || (cmd_i.prio_step && pair);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q     <= KIND_IGNORE;
      bidx_q     <= '0;
      sidx_out_q <= '0;
      didx_q     <= '0;
      fidx_q     <= '0;
      odm_q      <= '0;
      odc_q      <= '0;
      ofm_q      <= '0;
      ofc_q      <= '0;
      ofail_q    <= 1'b0;
      omask_q    <= '0;
      olast_q    <= 1'b0;
      if (cmd_i.emit_restart) begin
        kind_q <= KIND_RESTART;
        bidx_q <= 4'(tgt_q);
      end else if (cmd_i.emit_summary) begin
        kind_q  <= KIND_SUMMARY;
        bidx_q  <= 4'(tgt_q);
        odm_q   <= dm_q;
        odc_q   <= dc_q;
        ofm_q   <= fm_q;
        ofc_q   <= fc_q;
        ofail_q <= failed;
        omask_q <= failed ? vmask_q : full_mask;
      end else if (cmd_i.prio_step) begin
        kind_q <= KIND_PAIR;
        bidx_q <= 4'(tgt_q);
        didx_q <= di_q[4:0];
        fidx_q <= fi_q[4:0];
      end else begin
        olast_q <= 1'b1;
        if (wr_en) begin
          kind_q     <= KIND_STORE;
          bidx_q     <= 4'(st_idx_q);
          sidx_out_q <= slot;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign buffer_index_o = bidx_q;
  assign slot_index_o   = sidx_out_q;
  assign data_index_o   = didx_q;
  assign fec_index_o    = fidx_q;
  assign data_missing_o = odm_q;
  assign data_corrupt_o = odc_q;
  assign fec_missing_o  = ofm_q;
  assign fec_corrupt_o  = ofc_q;
  assign failed_o       = ofail_q;
  assign deliver_mask_o = omask_q;
  assign last_o         = olast_q;

  // Status
  assign sts_o.div_done   = div_done;
  assign sts_o.scan_last  = (sidx_q == LAST_BUF);
  assign sts_o.do_restart = evict && restart;
  assign sts_o.do_flush   = evict && !restart && min_live_q;
  assign sts_o.cnt_done   = cnt_done;
  assign sts_o.prio_done  = prio_done;
  assign sts_o.out_free   = out_free;

endmodule

### rtl/fec_block_erasure_planner_unit.sv
// FEC block erasure planner.
// in_ch carries one received packet per transaction: sequence number and CRC
// flag. out_ch carries result transactions: for a flushed block a summary
// (counts, failed flag, delivery mask) and then its data/FEC repair pairs; on
// a restart one restart result; and always last a store or ignore result
// with last set. cfg_we_i/cfg_idx_i/cfg_data_i write data_per_block (index
// 0) and fec_per_block (index 1); the user is to write them while the block
// is idle, which the block itself does not enforce.
// A packet passes through the serial divider, a sweep of the buffer table and
// the decide and store steps; once the final result is loaded the next packet
// can be taken. A flush adds a row read, the counting pass, the summary, the
// repair selection steps and a clear.
// One packet at a time; in_ch.ready is high only between packets.
// Reset empties all buffers and the slot marks and restores the registers.
// When the receiver stalls, the pending result is held and the planner waits
// before producing the next one.
module fec_block_erasure_planner_unit #(
  parameter int BLOCK_BUFFERS  = 1,
  parameter int MAX_PER_KIND   = 32,
  parameter int RESTART_WINDOW = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  fbep_in_if.sink     in_ch,
  fbep_out_if.source  out_ch
);
  import fbep_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fbep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbep_dp #(
    .BLOCK_BUFFERS  (BLOCK_BUFFERS),
    .MAX_PER_KIND   (MAX_PER_KIND),
    .RESTART_WINDOW (RESTART_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .seq_i          (in_ch.pkt_seq),
    .crc_i          (in_ch.crc_ok),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .kind_o         (out_ch.kind),
    .buffer_index_o (out_ch.buffer_index),
    .slot_index_o   (out_ch.slot_index),
    .data_index_o   (out_ch.data_index),
    .fec_index_o    (out_ch.fec_index),
    .data_missing_o (out_ch.data_missing),
    .data_corrupt_o (out_ch.data_corrupt),
    .fec_missing_o  (out_ch.fec_missing),
    .fec_corrupt_o  (out_ch.fec_corrupt),
    .failed_o       (out_ch.failed),
    .deliver_mask_o (out_ch.deliver_mask),
    .last_o         (out_ch.last)
  );

endmodule
